// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the resampler RTL.
// No dependencies; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HCR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HCR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define HCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/hcr_pkg.sv -----
// Shared constants and types of the Hermite cubic resampler.
// No dependencies.
package hcr_pkg;

    localparam int TAPS          = 4;
    localparam int Q_BITS        = 16;
    localparam int FRAC_BITS     = 32;
    localparam int POS_BITS      = 41;
    localparam int RATE_BITS     = 40;
    localparam int GLIDE_BITS    = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 40;
    localparam int JOB_Q_DEPTH   = 2;
    localparam int OUT_Q_DEPTH   = 2;

    localparam logic [RATE_BITS-1:0] RATE_MIN   = 40'd67108864;
    localparam logic [RATE_BITS-1:0] RATE_MAX   = 40'hFF_FFFF_FFFF;
    localparam logic [RATE_BITS-1:0] RATE_RESET = 40'h01_0000_0000;
    localparam logic [POS_BITS-1:0]  POS_ONE    = 41'h001_0000_0000;

    localparam logic [CFG_IDX_BITS-1:0] CFG_INITIAL_RATE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATE_GLIDE   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_OFFSET = 2'd2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_RUN  = 2'b10
    } t_front_state;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_T1   = 4'b0010,
        B_T2   = 4'b0100,
        B_T3   = 4'b1000
    } t_back_state;

endpackage

// ----- rtl/core/hcr_fifo.sv -----
// Small first-word-fall-through register queue.
// Depends on hcr_pkg (status struct).
module hcr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [WIDTH-1:0]    i_data,
    input  logic                i_pop,
    output logic [WIDTH-1:0]    o_data,
    output hcr_pkg::t_fifo_stat o_stat
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_BITS'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ----- rtl/core/hcr_front.sv -----
// Front end: sample window, read position, rate glide and run control.
// Emits one job (window, fraction, last flag) per output. Depends on hcr_pkg.
module hcr_front #(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_RUN     = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_in,
    output logic                                 o_full,
    input  logic                                 i_cfg_we,
    input  logic [hcr_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [hcr_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    output logic                                 o_job_push,
    output logic [hcr_pkg::TAPS*SAMPLE_BITS+hcr_pkg::Q_BITS:0] o_job_data,
    input  hcr_pkg::t_fifo_stat                  i_job_stat
);

    localparam int CNT_BITS  = $clog2(MAX_RUN + 1);
    localparam int POS_BITS  = hcr_pkg::POS_BITS;
    localparam int RATE_BITS = hcr_pkg::RATE_BITS;
    localparam int FRAC_BITS = hcr_pkg::FRAC_BITS;

    hcr_pkg::t_front_state r_state, n_state;

    logic [SAMPLE_BITS-1:0]         r_hist [hcr_pkg::TAPS];
    logic [SAMPLE_BITS-1:0]         n_hist [hcr_pkg::TAPS];
    logic [POS_BITS-1:0]            r_pos, n_pos;
    logic [RATE_BITS-1:0]           r_rate, n_rate;
    logic [hcr_pkg::GLIDE_BITS-1:0] r_glide, n_glide;
    logic [CNT_BITS-1:0]            r_cnt, n_cnt;

    logic                          w_below;
    logic [POS_BITS-1:0]           w_pos_step;
    logic signed [RATE_BITS+1:0]   w_rate_sum;
    logic [RATE_BITS-1:0]          w_rate_glided;
    logic [RATE_BITS-1:0]          w_cfg_rate;
    logic                          w_last;

    assign w_below    = (r_pos[POS_BITS-1:FRAC_BITS] == '0);
    assign w_pos_step = r_pos + POS_BITS'(r_rate);
    assign w_rate_sum = $signed({2'b00, r_rate}) + (RATE_BITS+2)'($signed(r_glide));
    assign w_last     = (w_pos_step[POS_BITS-1:FRAC_BITS] != '0)
                     || (r_cnt == CNT_BITS'(MAX_RUN - 1));
    assign w_cfg_rate = (i_cfg_data[RATE_BITS-1:0] < hcr_pkg::RATE_MIN)
                      ? hcr_pkg::RATE_MIN : i_cfg_data[RATE_BITS-1:0];

    always_comb begin
        if (w_rate_sum[RATE_BITS+1]
            || (w_rate_sum[RATE_BITS:0] < {1'b0, hcr_pkg::RATE_MIN})) begin
            w_rate_glided = hcr_pkg::RATE_MIN;
        end else if (w_rate_sum[RATE_BITS]) begin
            w_rate_glided = hcr_pkg::RATE_MAX;
        end else begin
            w_rate_glided = w_rate_sum[RATE_BITS-1:0];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_hist     = r_hist;
        n_pos      = r_pos;
        n_rate     = r_rate;
        n_glide    = r_glide;
        n_cnt      = r_cnt;
        o_job_push = 1'b0;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hcr_pkg::CFG_INITIAL_RATE: n_rate  = w_cfg_rate;
                hcr_pkg::CFG_RATE_GLIDE:   n_glide = i_cfg_data[hcr_pkg::GLIDE_BITS-1:0];
                hcr_pkg::CFG_START_OFFSET: n_pos   = POS_BITS'(i_cfg_data[FRAC_BITS-1:0]);
                default: ;
            endcase
        end

        unique case (r_state)
            hcr_pkg::F_IDLE: begin
                if (i_push) begin
                    for (int i = 0; i < hcr_pkg::TAPS - 1; i++) begin
                        n_hist[i] = r_hist[i+1];
                    end
                    n_hist[hcr_pkg::TAPS-1] = i_sample_in;
                    if (!w_below) begin
                        n_pos = r_pos - hcr_pkg::POS_ONE;
                    end
                    n_cnt   = '0;
                    n_state = hcr_pkg::F_RUN;
                end
            end
            hcr_pkg::F_RUN: begin
                if (!w_below) begin
                    n_state = hcr_pkg::F_IDLE;
                end else if (!i_job_stat.full) begin
                    o_job_push = 1'b1;
                    n_pos      = w_pos_step;
                    n_rate     = w_rate_glided;
                    n_cnt      = r_cnt + CNT_BITS'(1);
                    if (w_last) begin
                        n_state = hcr_pkg::F_IDLE;
                    end
                end
            end
            default: n_state = hcr_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hcr_pkg::F_IDLE;
            for (int i = 0; i < hcr_pkg::TAPS; i++) begin
                r_hist[i] <= '0;
            end
            r_pos   <= '0;
            r_rate  <= hcr_pkg::RATE_RESET;
            r_glide <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_hist  <= n_hist;
            r_pos   <= n_pos;
            r_rate  <= n_rate;
            r_glide <= n_glide;
            r_cnt   <= n_cnt;
        end
    end

    assign o_full     = (r_state == hcr_pkg::F_RUN);
    assign o_job_data = {w_last, r_pos[FRAC_BITS-1 -: hcr_pkg::Q_BITS],
                         r_hist[3], r_hist[2], r_hist[1], r_hist[0]};

endmodule

// ----- rtl/core/hcr_back.sv -----
// Back end: cubic Hermite evaluation by Horner on one shared multiplier,
// rounding and saturation. Depends on hcr_pkg.
module hcr_back #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [hcr_pkg::TAPS*SAMPLE_BITS+hcr_pkg::Q_BITS:0] i_job_data,
    input  hcr_pkg::t_fifo_stat  i_job_stat,
    output logic                 o_job_pop,
    output logic                 o_res_push,
    output logic [SAMPLE_BITS:0] o_res_data,
    input  hcr_pkg::t_fifo_stat  i_res_stat
);

    localparam int SB  = SAMPLE_BITS;
    localparam int QB  = hcr_pkg::Q_BITS;
    localparam int KW  = SB + 6;
    localparam int TW  = SB + 15;
    localparam int PW  = TW + QB + 1;
    localparam int AW  = SB + 34;
    localparam int SH1 = 8;
    localparam int SH2 = 16;
    localparam int SH3 = 25;
    localparam logic signed [AW-1:0] ROUND_HALF = {{(AW-SH3){1'b0}}, 1'b1, {(SH3-1){1'b0}}};

    hcr_pkg::t_back_state r_state, n_state;

    logic signed [TW-1:0] r_t, n_t;
    logic [QB-1:0]        r_q, n_q;
    logic signed [KW-1:0] r_b2, n_b2;
    logic signed [KW-1:0] r_c2, n_c2;
    logic signed [SB-1:0] r_x1, n_x1;
    logic                 r_last, n_last;

    logic signed [KW-1:0] w_e0, w_e1, w_e2, w_e3, w_d12, w_a2, w_b2, w_c2;
    logic signed [PW-1:0] w_prod;
    logic signed [AW-1:0] w_addend, w_acc, w_y;
    logic                 w_sat_hi, w_sat_lo;
    logic [SB-1:0]        w_sample;

    assign w_e0  = KW'($signed(i_job_data[0*SB +: SB]));
    assign w_e1  = KW'($signed(i_job_data[1*SB +: SB]));
    assign w_e2  = KW'($signed(i_job_data[2*SB +: SB]));
    assign w_e3  = KW'($signed(i_job_data[3*SB +: SB]));
    assign w_d12 = w_e1 - w_e2;
    assign w_c2  = w_e2 - w_e0;
    assign w_a2  = w_d12 + (w_d12 <<< 1) + (w_e3 - w_e0);
    assign w_b2  = w_e0 - (w_e1 <<< 1) + w_e2 - w_a2;

    assign w_prod = r_t * $signed({1'b0, r_q});

    always_comb begin
        unique case (r_state)
            hcr_pkg::B_T1: w_addend = AW'(r_b2) <<< 16;
            hcr_pkg::B_T2: w_addend = AW'(r_c2) <<< 24;
            hcr_pkg::B_T3: w_addend = (AW'(r_x1) <<< SH3) + ROUND_HALF;
            default:       w_addend = '0;
        endcase
    end

    assign w_acc    = AW'(w_prod) + w_addend;
    assign w_y      = w_acc >>> SH3;
    assign w_sat_hi = !w_y[AW-1] && (|w_y[AW-2:SB-1]);
    assign w_sat_lo = w_y[AW-1] && !(&w_y[AW-2:SB-1]);
    assign w_sample = w_sat_hi ? {1'b0, {(SB-1){1'b1}}}
                    : w_sat_lo ? {1'b1, {(SB-1){1'b0}}}
                    : w_y[SB-1:0];

    always_comb begin
        n_state    = r_state;
        n_t        = r_t;
        n_q        = r_q;
        n_b2       = r_b2;
        n_c2       = r_c2;
        n_x1       = r_x1;
        n_last     = r_last;
        o_job_pop  = 1'b0;
        o_res_push = 1'b0;
        unique case (r_state)
            hcr_pkg::B_IDLE: begin
                if (!i_job_stat.empty) begin
                    o_job_pop = 1'b1;
                    n_t       = TW'(w_a2);
                    n_q       = i_job_data[4*SB +: QB];
                    n_b2      = w_b2;
                    n_c2      = w_c2;
                    n_x1      = i_job_data[1*SB +: SB];
                    n_last    = i_job_data[4*SB+QB];
                    n_state   = hcr_pkg::B_T1;
                end
            end
            hcr_pkg::B_T1: begin
                n_t     = TW'(w_acc >>> SH1);
                n_state = hcr_pkg::B_T2;
            end
            hcr_pkg::B_T2: begin
                n_t     = TW'(w_acc >>> SH2);
                n_state = hcr_pkg::B_T3;
            end
            hcr_pkg::B_T3: begin
                if (!i_res_stat.full) begin
                    o_res_push = 1'b1;
                    n_state    = hcr_pkg::B_IDLE;
                end
            end
            default: n_state = hcr_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hcr_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t    <= n_t;
        r_q    <= n_q;
        r_b2   <= n_b2;
        r_c2   <= n_c2;
        r_x1   <= n_x1;
        r_last <= n_last;
    end

    assign o_res_data = {w_sample, r_last};

endmodule

// ----- rtl/core/hermite_cubic_resampler_unit.sv -----
// Top level of the 4-point cubic Hermite variable-rate resampler.
// Depends on hcr_pkg, hcr_fifo, hcr_front, hcr_back and assert_macros.svh.
//
// Usage: push one Q23 sample while full is low; it shifts into the four-sample
// window and the read position drops by one unless it is already below one.
// The front end then queues one job per output (up to MAX_RUN) and holds full
// high until the whole run is queued. For each output the back end loads the
// coefficients and then runs three Horner steps through a single multiplier;
// the last step waits while the result queue is full. Results leave through
// a two-entry queue (empty/pop); run_end marks the last output of each input
// sample. Configuration writes are taken at once and belong in idle periods
// only.
`include "assert_macros.svh"

module hermite_cubic_resampler_unit #(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_RUN     = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample_in,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [SAMPLE_BITS-1:0]     o_sample_out,
    output logic                              o_run_end,
    input  logic                              i_cfg_we,
    input  logic [hcr_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [hcr_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int JOB_BITS = hcr_pkg::TAPS * SAMPLE_BITS + hcr_pkg::Q_BITS + 1;
    localparam int RES_BITS = SAMPLE_BITS + 1;

    logic                w_job_push, w_job_pop;
    logic [JOB_BITS-1:0] w_job_in, w_job_out;
    hcr_pkg::t_fifo_stat w_job_stat;

    logic                w_res_push;
    logic [RES_BITS-1:0] w_res_in, w_res_out;
    hcr_pkg::t_fifo_stat w_res_stat;

    hcr_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_RUN     (MAX_RUN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_sample_in (i_sample_in),
        .o_full      (full),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_job_push  (w_job_push),
        .o_job_data  (w_job_in),
        .i_job_stat  (w_job_stat)
    );

    hcr_fifo #(
        .WIDTH (JOB_BITS),
        .DEPTH (hcr_pkg::JOB_Q_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .i_pop   (w_job_pop),
        .o_data  (w_job_out),
        .o_stat  (w_job_stat)
    );

    hcr_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_data (w_job_out),
        .i_job_stat (w_job_stat),
        .o_job_pop  (w_job_pop),
        .o_res_push (w_res_push),
        .o_res_data (w_res_in),
        .i_res_stat (w_res_stat)
    );

    hcr_fifo #(
        .WIDTH (RES_BITS),
        .DEPTH (hcr_pkg::OUT_Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .i_pop   (pop && !w_res_stat.empty),
        .o_data  (w_res_out),
        .o_stat  (w_res_stat)
    );

    assign empty        = w_res_stat.empty;
    assign o_sample_out = w_res_out[RES_BITS-1:1];
    assign o_run_end    = w_res_out[0];

    `HCR_ASSERT_IMPL(a_job_only_when_busy, i_clk, i_rst_n, w_job_push, full)
    `HCR_ASSERT_IMPL(a_job_q_no_overflow, i_clk, i_rst_n, w_job_push, !w_job_stat.full)
    `HCR_ASSERT_IMPL(a_job_q_no_underflow, i_clk, i_rst_n, w_job_pop, !w_job_stat.empty)
    `HCR_ASSERT_IMPL(a_res_q_no_overflow, i_clk, i_rst_n, w_res_push, !w_res_stat.full)
    `HCR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, push && !full, full)

endmodule
